@@ rtl/ffa_pkg.sv @@
// package: widths, codes, states and types of the first-fit max tree allocator
`default_nettype none
package ffa_pkg;

  localparam int BIN_COUNT_DEF = 1024;
  localparam int VAL_W         = 32;
  localparam int AMT_W         = 31;
  localparam int IDX_W         = 10;
  localparam int MISS_W        = 16;
  localparam int OP_W          = 2;

  localparam logic [VAL_W-1:0]  EMPTY_MARK = {VAL_W{1'b1}};
  localparam logic [MISS_W-1:0] MISS_MAX   = {MISS_W{1'b1}};

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROOT,
    S_DESC,
    S_UP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             ge;
    logic [VAL_W-1:0] mx;
  } cmp_res_t;

endpackage
`default_nettype wire

@@ rtl/ffa_ifs.sv @@
// interfaces: request channel and result channel of the allocator
`default_nettype none
interface ffa_in_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  bin_index;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, output operation, output bin_index, output amount,
                  input ready);
  modport sink   (input valid, input operation, input bin_index, input amount,
                  output ready);
endinterface

interface ffa_out_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              placed;
  logic [IDX_W-1:0]  placed_index;
  logic [MISS_W-1:0] miss_total;

  modport source (output valid, output placed, output placed_index, output miss_total,
                  input ready);
  modport sink   (input valid, input placed, input placed_index, input miss_total,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/ffa_ram.sv @@
// generic ram: one write port, one read port with registered read data
`default_nettype none
module ffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/ffa_cmp.sv @@
// shared compare unit: signed a >= b and the larger of the two
`default_nettype none
module ffa_cmp import ffa_pkg::*; (
  input  wire logic [VAL_W-1:0] a,
  input  wire logic [VAL_W-1:0] b,
  output cmp_res_t              res
);

  always_comb begin
    res.ge = ($signed(a) >= $signed(b));
    res.mx = res.ge ? a : b;
  end

endmodule
`default_nettype wire

@@ rtl/first_fit_max_tree_allocator_core.sv @@
// top level: sequencer of the first-fit max tree allocator
//
//  channel  dir  signals                                    beat
//  in_ch    in   operation, bin_index, amount               load, place or clear
//  out_ch   out  placed, placed_index, miss_total           one per place
//
// load: leaf write, then one tree level per cycle on the ram read port up to the root
// place hit: root read, descent, ancestor refresh, result
// place miss: root read, result; clear: zeroes the miss count, then sweeps every node;
// reset: sweep of all 2*leaves nodes (2048 by default)
// in_ch.ready is high only between items; a waiting result stalls only the next place
`default_nettype none
module first_fit_max_tree_allocator_core import ffa_pkg::*; #(
  parameter int BIN_COUNT = BIN_COUNT_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ffa_in_if.sink   in_ch,
  ffa_out_if.source out_ch
);

  localparam int LEAF_W = $clog2(BIN_COUNT);
  localparam int NODE_W = LEAF_W + 1;
  localparam int DEPTH  = 1 << NODE_W;
  localparam int BX_W   = (LEAF_W > IDX_W) ? LEAF_W : IDX_W;
  localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);

  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [NODE_W-1:0]   leaf_r, leaf_nxt;
  logic [NODE_W-1:0]   clr_r, clr_nxt;
  logic [VAL_W-1:0]    cur_r, cur_nxt;
  logic [AMT_W-1:0]    amt_r, amt_nxt;
  logic                pl_r, pl_nxt;
  logic                hit_r, hit_nxt;
  logic [MISS_W-1:0]   miss_r, miss_nxt;
  logic                ov_r, ov_nxt;
  logic                op_r, op_nxt;
  logic [IDX_W-1:0]    oi_r, oi_nxt;
  logic [MISS_W-1:0]   om_r, om_nxt;

  logic                ram_we;
  logic [NODE_W-1:0]   ram_waddr, ram_raddr;
  logic [VAL_W-1:0]    ram_wdata, ram_rdata;
  logic [VAL_W-1:0]    cmp_b;
  cmp_res_t            cmp;

  logic                accept, bin_ok;
  logic [BX_W-1:0]     bin_x, idx_x;
  logic [NODE_W-1:0]   leaf_in, child, par;

  ffa_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmp_b = (state_r == S_UP) ? cur_r : {1'b0, amt_r};

  ffa_cmp u_cmp (
    .a   (ram_rdata),
    .b   (cmp_b),
    .res (cmp)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign bin_ok              = (32'(in_ch.bin_index) < 32'(BIN_COUNT));
  assign bin_x               = BX_W'(in_ch.bin_index);
  assign leaf_in             = {1'b1, bin_x[LEAF_W-1:0]};
  assign child               = {node_r[NODE_W-2:0], ~cmp.ge};
  assign par                 = node_r >> 1;
  assign idx_x               = BX_W'(leaf_r[LEAF_W-1:0]);

  assign out_ch.valid        = ov_r;
  assign out_ch.placed       = op_r;
  assign out_ch.placed_index = oi_r;
  assign out_ch.miss_total   = om_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      miss_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      miss_r  <= miss_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    leaf_r <= leaf_nxt;
    cur_r  <= cur_nxt;
    amt_r  <= amt_nxt;
    pl_r   <= pl_nxt;
    hit_r  <= hit_nxt;
    op_r   <= op_nxt;
    oi_r   <= oi_nxt;
    om_r   <= om_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    node_nxt  = node_r;
    leaf_nxt  = leaf_r;
    clr_nxt   = clr_r;
    cur_nxt   = cur_r;
    amt_nxt   = amt_r;
    pl_nxt    = pl_r;
    hit_nxt   = hit_r;
    miss_nxt  = miss_r;
    ov_nxt    = ov_r && !out_ch.ready;
    op_nxt    = op_r;
    oi_nxt    = oi_r;
    om_nxt    = om_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = EMPTY_MARK;
    ram_raddr = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + NODE_W'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          amt_nxt = in_ch.amount;
          case (in_ch.operation)
            OP_LOAD: begin
              if (bin_ok) begin
                ram_we    = 1'b1;
                ram_waddr = leaf_in;
                ram_wdata = {1'b0, in_ch.amount};
                cur_nxt   = {1'b0, in_ch.amount};
                node_nxt  = leaf_in;
                ram_raddr = leaf_in ^ NODE_W'(1);
                pl_nxt    = 1'b0;
                state_nxt = S_UP;
              end
            end
            OP_PLACE: begin
              ram_raddr = ROOT;
              pl_nxt    = 1'b1;
              state_nxt = S_ROOT;
            end
            OP_CLEAR: begin
              miss_nxt  = '0;
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_ROOT: begin
        if (!cmp.ge) begin
          hit_nxt   = 1'b0;
          state_nxt = S_OUT;
        end else begin
          node_nxt  = ROOT;
          ram_raddr = NODE_W'(2);
          state_nxt = S_DESC;
        end
      end
      S_DESC: begin
        node_nxt = child;
        if (child[NODE_W-1]) begin
          ram_we    = 1'b1;
          ram_waddr = child;
          ram_wdata = EMPTY_MARK;
          cur_nxt   = EMPTY_MARK;
          leaf_nxt  = child;
          hit_nxt   = 1'b1;
          ram_raddr = child ^ NODE_W'(1);
          state_nxt = S_UP;
        end else begin
          ram_raddr = {child[NODE_W-2:0], 1'b0};
        end
      end
      S_UP: begin
        ram_we    = 1'b1;
        ram_waddr = par;
        ram_wdata = cmp.mx;
        cur_nxt   = cmp.mx;
        node_nxt  = par;
        if (par == ROOT) begin
          state_nxt = pl_r ? S_OUT : S_IDLE;
        end else begin
          ram_raddr = par ^ NODE_W'(1);
        end
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          op_nxt    = hit_r;
          oi_nxt    = hit_r ? idx_x[IDX_W-1:0] : '0;
          om_nxt    = miss_r;
          if (!hit_r && (miss_r != MISS_MAX)) begin
            miss_nxt = miss_r + MISS_W'(1);
            om_nxt   = miss_r + MISS_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ch.ready)
    else $error("request taken during clearing sweep");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside result state");

  a_miss_drop_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (miss_r < $past(miss_r))) |-> (state_r == S_CLEAR))
    else $error("miss count fell without a clear");

  a_refresh_below_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP) |-> (node_r > ROOT))
    else $error("refresh started at the root");
`endif

endmodule
`default_nettype wire
